// ----- design/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, prop, msg) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- design/tegr_pkg.sv -----
package tegr_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned CellCount = MaxWidth * MaxHeight;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned YW        = $clog2(MaxHeight);
  localparam logic [31:0] InvSqrt2Q30 = 32'd759250125;
  localparam logic [47:0] MovedMax  = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdRun   = 2'd2;

  localparam logic [2:0] CfgWidth  = 3'd0;
  localparam logic [2:0] CfgHeight = 3'd1;
  localparam logic [2:0] CfgIter   = 3'd2;
  localparam logic [2:0] CfgTalus  = 3'd3;
  localparam logic [2:0] CfgRelax  = 3'd4;
  localparam logic [2:0] CfgDiag   = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        in_range;
    logic [15:0] cell_index;
    logic [31:0] height_value;
  } tegr_op_t;

  typedef struct packed {
    logic [31:0] read_height;
    logic [47:0] moved_total;
    logic [15:0] passes_done;
  } tegr_res_t;

  typedef struct packed {
    logic [8:0]  w;
    logic [8:0]  h;
    logic [15:0] iter;
    logic [30:0] talus;
    logic [16:0] rel;
    logic        diag;
  } tegr_cfg_t;
endpackage

// ----- design/tegr_if.sv -----
interface tegr_cmd_if;
  import tegr_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] cell_index;
  logic signed [31:0] height_value;
  modport source (output valid, cmd, cell_index, height_value, input ready);
  modport sink (input valid, cmd, cell_index, height_value, output ready);
endinterface

interface tegr_res_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_height;
  logic [47:0] moved_total;
  logic [15:0] passes_done;
  modport source (output valid, read_height, moved_total, passes_done, input ready);
  modport sink (input valid, read_height, moved_total, passes_done, output ready);
endinterface

// ----- design/tegr_front.sv -----
module tegr_front import tegr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tegr_cmd_if.sink  cmd_if,
  input  tegr_cfg_t cfg_i,
  output logic      q_valid_o,
  input  logic      q_ready_i,
  output tegr_op_t  q_op_o
);
  // two-entry queue of classified commands
  tegr_op_t   ent_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic [8:0] w, h;
  logic [17:0] cells;
  tegr_op_t   op;
  logic       push, pop;

  always_comb begin
    w = (cfg_i.w == 9'd0) ? 9'd1 : ((cfg_i.w > 9'(MaxWidth)) ? 9'(MaxWidth) : cfg_i.w);
    h = (cfg_i.h == 9'd0) ? 9'd1 : ((cfg_i.h > 9'(MaxHeight)) ? 9'(MaxHeight) : cfg_i.h);
    cells = 18'(w) * 18'(h);
    op.cmd = cmd_if.cmd;
    op.cell_index = cmd_if.cell_index;
    op.height_value = cmd_if.height_value;
    op.in_range = 18'(cmd_if.cell_index) < cells;
  end

  assign cmd_if.ready = (cnt_q != 2'd2);
  assign push = cmd_if.valid && cmd_if.ready;
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_op_o = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= op;
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_no_overflow, cnt_q > 2'd2, "queue count out of range")
  `ASSERT_NEVER(a_no_underflow, pop && cnt_q == 2'd0, "pop from empty queue")
  `ASSERT_IMPL(a_full_stall, cnt_q == 2'd2 |-> !cmd_if.ready, "accepted while full")
endmodule

// ----- design/tegr_back.sv -----
module tegr_back import tegr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tegr_cfg_t cfg_i,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  tegr_op_t  q_op_i,
  tegr_res_if.source res_if
);
  // States
  localparam logic [3:0] SIdle = 4'd0, SClr = 4'd1, SCen = 4'd2, SNb = 4'd3,
                         SNbW = 4'd4, SCalc = 4'd5, SMul = 4'd6, SAcc = 4'd7,
                         SApR = 4'd8, SApW = 4'd9, SPass = 4'd10, SRdW = 4'd11,
                         SAcc2 = 4'd13, SDone = 4'd14;

  logic signed [31:0] hmem [CellCount];
  logic signed [39:0] dmem [CellCount];

  logic [3:0]  st_q;
  logic [AddrW-1:0] haddr, daddr;
  logic signed [31:0] hrd_q;
  logic signed [39:0] drd_q;
  logic        hwe, dwe;
  logic signed [31:0] hwd;
  logic signed [39:0] dwd;

  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [2:0]  k_q;
  logic signed [31:0] hc_q;
  logic [32:0] drop_q;
  logic [32:0] slope_q;
  logic [33:0] amt_q;
  logic [AddrW-1:0] dst_q, src_q, i_q;
  logic [47:0] moved_q, total_q;
  logic [15:0] passes_q;
  logic [47:0] pass_moved_q;
  tegr_res_t   res_q;
  logic        out_v_q;
  logic [8:0]  w, h;
  logic [16:0] rel;
  logic [16:0] cells_m1;

  always_comb begin
    w = (cfg_i.w == 9'd0) ? 9'd1 : ((cfg_i.w > 9'(MaxWidth)) ? 9'(MaxWidth) : cfg_i.w);
    h = (cfg_i.h == 9'd0) ? 9'd1 : ((cfg_i.h > 9'(MaxHeight)) ? 9'(MaxHeight) : cfg_i.h);
    rel = (cfg_i.rel > 17'd65536) ? 17'd65536 : cfg_i.rel;
    cells_m1 = 17'(18'(w) * 18'(h) - 18'd1);
  end

  // neighbour offsets
  logic signed [1:0] dx, dy;
  always_comb begin
    case (k_q)
      3'd0: begin dx = 2'sd1;  dy = 2'sd0;  end
      3'd1: begin dx = 2'sd1;  dy = 2'sd1;  end
      3'd2: begin dx = 2'sd0;  dy = 2'sd1;  end
      3'd3: begin dx = -2'sd1; dy = 2'sd1;  end
      3'd4: begin dx = -2'sd1; dy = 2'sd0;  end
      3'd5: begin dx = -2'sd1; dy = -2'sd1; end
      3'd6: begin dx = 2'sd0;  dy = -2'sd1; end
      default: begin dx = 2'sd1; dy = -2'sd1; end
    endcase
  end
  logic signed [10:0] nx, ny;
  logic nb_in;
  logic [AddrW-1:0] nb_addr;
  always_comb begin
    nx = 11'(x_q) + 11'(dx);
    ny = 11'(y_q) + 11'(dy);
    nb_in = (nx >= 0) && (nx < 11'(w)) && (ny >= 0) && (ny < 11'(h));
    nb_addr = AddrW'(18'(ny[8:0]) * 18'(w) + 18'(nx[8:0]));
  end

  // pipeline of the slope/amount math
  logic [64:0] diag_prod;
  logic [50:0] rel_prod;
  logic [32:0] ex;
  assign diag_prod = 65'(drop_q) * 65'(InvSqrt2Q30);
  assign ex = slope_q - 33'(cfg_i.talus);
  assign rel_prod = 51'(ex) * 51'(rel);

  // apply stage
  logic signed [40:0] nv;
  logic signed [31:0] nv_sat;
  logic [32:0] absd;
  always_comb begin
    nv = 41'(hrd_q) + 41'(drd_q);
    if (nv > 41'sd2147483647) nv_sat = 32'sh7FFFFFFF;
    else if (nv < -41'sd2147483648) nv_sat = 32'sh80000000;
    else nv_sat = nv[31:0];
    absd = (nv_sat >= hrd_q) ? 33'(34'(nv_sat) - 34'(hrd_q)) : 33'(34'(hrd_q) - 34'(nv_sat));
  end

  logic [48:0] tsum;
  assign tsum = 49'(total_q) + 49'(pass_moved_q);
  logic [48:0] pm_sum;
  assign pm_sum = 49'(pass_moved_q) + 49'(absd);

  always_comb begin
    hwe = 1'b0; dwe = 1'b0; hwd = q_op_i.height_value; dwd = '0;
    haddr = q_op_i.cell_index[AddrW-1:0]; daddr = i_q;
    case (st_q)
      SIdle: begin
        hwe = q_valid_i && q_ready_o && q_op_i.cmd == CmdWrite && q_op_i.in_range;
      end
      SClr: begin dwe = 1'b1; daddr = i_q; end
      SCen: haddr = src_q;
      SNb: haddr = nb_addr;
      SAcc: daddr = dst_q;
      SAcc2: begin dwe = 1'b1; daddr = dst_q; dwd = drd_q + 40'(amt_q); end
      SMul: daddr = src_q;
      SApR: begin haddr = i_q; daddr = i_q; end
      SApW: begin hwe = (drd_q != 0); haddr = i_q; hwd = nv_sat; end
      default: ;
    endcase
  end
  // source-side decrement written in SAcc while the destination is read
  logic dsrc_we;
  assign dsrc_we = (st_q == SAcc);

  always_ff @(posedge clk_i) begin
    if (hwe) hmem[haddr] <= hwd;
    hrd_q <= hmem[haddr];
  end
  always_ff @(posedge clk_i) begin
    if (dwe) dmem[daddr] <= dwd;
    else if (dsrc_we) dmem[src_q] <= drd_q - 40'(amt_q);
    drd_q <= dmem[daddr];
  end

  assign q_ready_o = (st_q == SIdle) && !out_v_q;
  assign res_if.valid = out_v_q;
  assign res_if.read_height = res_q.read_height;
  assign res_if.moved_total = res_q.moved_total;
  assign res_if.passes_done = res_q.passes_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      out_v_q <= 1'b0;
    end else begin
      if (out_v_q && res_if.ready) out_v_q <= 1'b0;
      case (st_q)
        SIdle: if (q_valid_i && !out_v_q) begin
          res_q <= '0;
          total_q <= '0; passes_q <= '0;
          if (q_op_i.cmd == CmdRead && q_op_i.in_range) st_q <= SRdW;
          else if (q_op_i.cmd == CmdRun && cfg_i.iter != 16'd0) begin
            st_q <= SClr; i_q <= '0;
          end else out_v_q <= 1'b1;
        end
        SRdW: begin res_q.read_height <= hrd_q; out_v_q <= 1'b1; st_q <= SIdle; end
        SClr: begin
          if (i_q == AddrW'(cells_m1)) begin
            st_q <= SCen; x_q <= '0; y_q <= '0; src_q <= '0; k_q <= '0;
            pass_moved_q <= '0;
          end
          i_q <= i_q + 1'b1;
        end
        SCen: st_q <= SNb;
        SNb: begin
          if (k_q == 3'd0) hc_q <= hrd_q;
          if (nb_in) begin dst_q <= nb_addr; st_q <= SNbW; end
          else st_q <= SPass;
        end
        SNbW: begin
          drop_q <= 33'(34'(hc_q) - 34'(hrd_q));
          st_q <= ($signed(34'(hc_q) - 34'(hrd_q)) > 0) ? SCalc : SPass;
        end
        SCalc: begin
          slope_q <= (k_q[0] && cfg_i.diag) ? 33'(diag_prod >> 30) : drop_q;
          st_q <= SMul;
        end
        SMul: begin
          amt_q <= (slope_q > 33'(cfg_i.talus)) ? 34'(rel_prod >> 16) : '0;
          st_q <= (slope_q > 33'(cfg_i.talus)) ? SAcc : SPass;
        end
        SAcc: st_q <= SAcc2;
        SAcc2: st_q <= SPass;
        SPass: begin
          // next neighbour or next cell
          if (k_q != 3'd7) begin k_q <= k_q + 1'b1; st_q <= SNb; end
          else begin
            k_q <= '0;
            if (src_q == AddrW'(cells_m1)) begin i_q <= '0; st_q <= SApR; end
            else begin
              src_q <= src_q + 1'b1; st_q <= SCen;
              if (9'(x_q) + 9'd1 == w) begin x_q <= '0; y_q <= y_q + 1'b1; end
              else x_q <= x_q + 1'b1;
            end
          end
        end
        SApR: st_q <= SApW;
        SApW: begin
          if (drd_q != 0) pass_moved_q <= pm_sum[48] ? MovedMax : pm_sum[47:0];
          if (i_q == AddrW'(cells_m1)) st_q <= SDone;
          else begin i_q <= i_q + 1'b1; st_q <= SApR; end
        end
        SDone: begin
          passes_q <= passes_q + 1'b1;
          total_q <= tsum[48] ? MovedMax : tsum[47:0];
          if (pass_moved_q == 0 || passes_q + 16'd1 == cfg_i.iter) begin
            res_q.moved_total <= tsum[48] ? MovedMax : tsum[47:0];
            res_q.passes_done <= passes_q + 1'b1;
            out_v_q <= 1'b1; st_q <= SIdle;
          end else begin st_q <= SClr; i_q <= '0; end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_hold, out_v_q && !res_if.ready |=> out_v_q, "result dropped")
  `ASSERT_NEVER(a_ready_busy, q_ready_o && out_v_q, "ready while result held")
  `ASSERT_IMPL(a_run_cnt, st_q == SDone |-> passes_q < cfg_i.iter, "pass overrun")
endmodule

// ----- design/thermal_erosion_grid_relax.sv -----
// Thermal erosion engine over a heightmap of up to 256 x 256 Q16.16 cells.
// Channels: cmd_if (cmd, cell_index, height_value) in, res_if
// (read_height, moved_total, passes_done) out, valid/ready transfers.
// Config: cfg_we_i, cfg_index_i, cfg_data_i, written only when idle; the
// user must keep to this, the block does not enforce it. Commands enter a
// two-entry queue; a sequencer executes them in order and takes the next
// one only once the previous result has been transferred.
// Write, unused command, out-of-range read, zero-limit run: the result is
// set straight from the idle state. In-range read: through the read state.
// Run: per pass, a clear sweep over every cell, then per cell a centre read
// and per neighbour a read and compare, slope and amount steps for a lower
// neighbour and accumulate steps when material moves, then a read and a
// write apply per cell and a closing step.
// Runs end at the iteration limit or after a pass that moves nothing.
// Reset clears the queue and sequencer; heights are undefined until
// written. A stalled receiver holds the result and the block takes no
// further command from the queue, which then fills and drops ready.
module thermal_erosion_grid_relax import tegr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tegr_cmd_if.sink    cmd_if,
  tegr_res_if.source  res_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  tegr_cfg_t cfg_q;
  logic      qv, qr;
  tegr_op_t  qop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{w: 9'd256, h: 9'd256, iter: 16'd50, talus: 31'd32768,
                 rel: 17'd32768, diag: 1'b1};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgWidth:  cfg_q.w <= cfg_data_i[8:0];
        CfgHeight: cfg_q.h <= cfg_data_i[8:0];
        CfgIter:   cfg_q.iter <= cfg_data_i[15:0];
        CfgTalus:  cfg_q.talus <= cfg_data_i;
        CfgRelax:  cfg_q.rel <= cfg_data_i[16:0];
        CfgDiag:   cfg_q.diag <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tegr_front u_front (.clk_i, .rst_ni, .cmd_if, .cfg_i(cfg_q),
                      .q_valid_o(qv), .q_ready_i(qr), .q_op_o(qop));
  tegr_back u_back (.clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(qv),
                    .q_ready_o(qr), .q_op_i(qop), .res_if);
endmodule
